### rtl/rlfe_pkg.sv
// types, state codes and constants shared by the rgb led fade engine
// no dependencies; used by rlfe_ctrl, rlfe_dp and the top level
package rlfe_pkg;

	localparam int unsigned DIV_STEPS = 24;
	localparam logic [7:0]  UPDATE_STEP_RESET = 8'd10;
	localparam logic [15:0] STEP_MAX = 16'hFFFF;
	localparam logic [7:0]  BLEND_FULL = 8'hFF;
	localparam logic [7:0]  BLEND_NONE = 8'h00;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	typedef struct packed {
		color_t      cur;
		color_t      start;
		color_t      tgt;
		logic [15:0] pos;
		logic [15:0] inc;
	} led_rec_t;

	typedef enum logic [1:0] {
		CH_R,
		CH_G,
		CH_B
	} chan_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SET_RD,
		ST_SET_WR,
		ST_TK_RD,
		ST_TK_R,
		ST_TK_G,
		ST_TK_B,
		ST_TK_WR
	} state_t;

	typedef struct packed {
		logic  in_load;
		logic  led_zero;
		logic  led_index;
		logic  led_inc;
		logic  div_start;
		logic  div_step;
		logic  mix_en;
		chan_t mix_ch;
		logic  wr_set;
		logic  wr_tick;
		logic  out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_mode;
		logic in_target_ok;
		logic in_all;
		logic div_last;
		logic led_last;
		logic set_single;
		logic out_free;
	} ctrl_sts_t;

endpackage

### rtl/rgb_led_fade_engine_unit.sv
// tick: the leds are walked in order, one result per led, each led taking a read,
// three channel mixes on one shared multiplier pair and a write-back in turn
// set: step divider, then a read then write of the state ram for each led written
// output stalls hold the walk in the write-back step; a new transaction is taken when idle
// reset: update_step returns to 10, per-led valid bits clear so all led state reads as zero
// no clearing pass; depends on rlfe_pkg, rlfe_ctrl, rlfe_dp
module rgb_led_fade_engine_unit #(
	parameter int LED_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // led_index, color_red, color_green, color_blue, fade_time
	input  logic [0:0]  s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // led_number, led_red, led_green, led_blue, zero pad
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	rlfe_pkg::ctrl_cmd_t cmd;
	rlfe_pkg::ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	rlfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rlfe_dp #(
		.LED_COUNT (LED_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_mode   (s_axis_tuser[0]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

### rtl/rlfe_ctrl.sv
// sequencing state machine for the fade engine
// depends on rlfe_pkg; drives rlfe_dp through ctrl_cmd_t
module rlfe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rlfe_pkg::ctrl_sts_t  sts,
	output rlfe_pkg::ctrl_cmd_t  cmd
);

	rlfe_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rlfe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					if (sts.in_mode) begin
						cmd.led_zero = 1'b1;
						state_d      = rlfe_pkg::ST_TK_RD;
					end else if (sts.in_target_ok) begin
						cmd.div_start = 1'b1;
						if (sts.in_all) begin
							cmd.led_zero = 1'b1;
						end else begin
							cmd.led_index = 1'b1;
						end
						state_d = rlfe_pkg::ST_DIV;
					end
				end
			end
			rlfe_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = rlfe_pkg::ST_SET_RD;
				end
			end
			rlfe_pkg::ST_SET_RD: begin
				state_d = rlfe_pkg::ST_SET_WR;
			end
			rlfe_pkg::ST_SET_WR: begin
				cmd.wr_set = 1'b1;
				if (sts.set_single || sts.led_last) begin
					state_d = rlfe_pkg::ST_IDLE;
				end else begin
					cmd.led_inc = 1'b1;
					state_d     = rlfe_pkg::ST_SET_RD;
				end
			end
			rlfe_pkg::ST_TK_RD: begin
				state_d = rlfe_pkg::ST_TK_R;
			end
			rlfe_pkg::ST_TK_R: begin
				cmd.mix_en = 1'b1;
				cmd.mix_ch = rlfe_pkg::CH_R;
				state_d    = rlfe_pkg::ST_TK_G;
			end
			rlfe_pkg::ST_TK_G: begin
				cmd.mix_en = 1'b1;
				cmd.mix_ch = rlfe_pkg::CH_G;
				state_d    = rlfe_pkg::ST_TK_B;
			end
			rlfe_pkg::ST_TK_B: begin
				cmd.mix_en = 1'b1;
				cmd.mix_ch = rlfe_pkg::CH_B;
				state_d    = rlfe_pkg::ST_TK_WR;
			end
			rlfe_pkg::ST_TK_WR: begin
				// hold the led until the output register can take its result
				if (sts.out_free) begin
					cmd.wr_tick  = 1'b1;
					cmd.out_load = 1'b1;
					if (sts.led_last) begin
						state_d = rlfe_pkg::ST_IDLE;
					end else begin
						cmd.led_inc = 1'b1;
						state_d     = rlfe_pkg::ST_TK_RD;
					end
				end
			end
			default: begin
				state_d = rlfe_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/rlfe_dp.sv
// datapath: led state memory, step divider, channel mixer and output register
// depends on rlfe_pkg; controlled by rlfe_ctrl
module rlfe_dp #(
	parameter int LED_COUNT = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [47:0]          in_data,
	input  logic                 in_mode,
	input  logic                 cfg_valid,
	input  logic [7:0]           cfg_data,
	input  rlfe_pkg::ctrl_cmd_t  cmd,
	output rlfe_pkg::ctrl_sts_t  sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          out_data,
	output logic                 out_last
);

	localparam int LED_AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [LED_AW-1:0] LED_LAST = LED_AW'(LED_COUNT - 1);
	localparam logic [4:0] DIV_LAST = 5'(rlfe_pkg::DIV_STEPS - 1);

	// input fields
	logic [7:0]       in_idx;
	rlfe_pkg::color_t in_color;
	logic [15:0]      in_ft;

	assign in_idx     = in_data[7:0];
	assign in_color.r = in_data[15:8];
	assign in_color.g = in_data[23:16];
	assign in_color.b = in_data[31:24];
	assign in_ft      = in_data[47:32];

	logic [7:0]       update_step_q;
	rlfe_pkg::color_t color_q;
	logic [15:0]      ft_q;
	logic             all_q;
	logic [LED_AW-1:0] led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_step_q <= rlfe_pkg::UPDATE_STEP_RESET;
		end else if (cfg_valid) begin
			update_step_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			color_q <= in_color;
			ft_q    <= in_ft;
			all_q   <= (in_idx == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= '0;
		end else if (cmd.led_zero) begin
			led_q <= '0;
		end else if (cmd.led_index) begin
			led_q <= in_idx[LED_AW-1:0];
		end else if (cmd.led_inc) begin
			led_q <= led_q + 1'b1;
		end
	end

	// restoring divider for 65535*update_step / fade_time, one quotient bit a cycle
	logic [23:0] num_q;
	logic [15:0] rem_q;
	logic [4:0]  div_cnt_q;
	logic [16:0] div_sh;
	logic        div_ge;
	logic [16:0] div_rem;
	logic [15:0] step;

	assign div_sh  = {rem_q, num_q[23]};
	assign div_ge  = div_sh >= {1'b0, ft_q};
	assign div_rem = div_ge ? (div_sh - {1'b0, ft_q}) : div_sh;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q     <= {update_step_q, 16'd0} - {16'd0, update_step_q};
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			num_q     <= {num_q[22:0], div_ge};
			rem_q     <= div_rem[15:0];
			div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	assign step = ((ft_q == 16'd0) || (num_q[23:16] != 8'd0)) ? rlfe_pkg::STEP_MAX
		: num_q[15:0];

	// led state memory; an entry never written reads as zero
	rlfe_pkg::led_rec_t mem [LED_COUNT];
	rlfe_pkg::led_rec_t rd_q;
	logic [LED_COUNT-1:0] vld_q;
	logic                 rd_vld_q;
	rlfe_pkg::led_rec_t rec_rd;
	rlfe_pkg::led_rec_t wr_rec;
	logic                 wr_en;

	assign wr_en = cmd.wr_set || cmd.wr_tick;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[led_q] <= wr_rec;
		end
		rd_q <= mem[led_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[led_q] <= 1'b1;
			end
			rd_vld_q <= vld_q[led_q];
		end
	end

	assign rec_rd = rd_vld_q ? rd_q : '0;

	// channel mixer, one channel a cycle
	rlfe_pkg::led_rec_t wk_q;
	rlfe_pkg::led_rec_t mix_src;
	rlfe_pkg::led_rec_t wk_d;
	logic [7:0]  blend;
	logic [8:0]  keep;
	logic [7:0]  ch_cur;
	logic [7:0]  ch_start;
	logic [7:0]  ch_tgt;
	logic [16:0] prod_keep;
	logic [15:0] prod_tgt;
	logic [7:0]  ch_new;

	assign mix_src = (cmd.mix_ch == rlfe_pkg::CH_R) ? rec_rd : wk_q;
	assign blend   = mix_src.pos[15:8];
	assign keep    = 9'd256 - {1'b0, blend};

	always_comb begin
		case (cmd.mix_ch)
			rlfe_pkg::CH_R: begin
				ch_cur   = mix_src.cur.r;
				ch_start = mix_src.start.r;
				ch_tgt   = mix_src.tgt.r;
			end
			rlfe_pkg::CH_G: begin
				ch_cur   = mix_src.cur.g;
				ch_start = mix_src.start.g;
				ch_tgt   = mix_src.tgt.g;
			end
			rlfe_pkg::CH_B: begin
				ch_cur   = mix_src.cur.b;
				ch_start = mix_src.start.b;
				ch_tgt   = mix_src.tgt.b;
			end
			default: begin
				ch_cur   = mix_src.cur.r;
				ch_start = mix_src.start.r;
				ch_tgt   = mix_src.tgt.r;
			end
		endcase
	end

	assign prod_keep = {9'd0, ch_cur} * keep;
	assign prod_tgt  = {8'd0, ch_tgt} * {8'd0, blend};

	always_comb begin
		if (blend == rlfe_pkg::BLEND_FULL) begin
			ch_new = ch_tgt;
		end else if (blend == rlfe_pkg::BLEND_NONE) begin
			ch_new = ch_start;
		end else begin
			ch_new = prod_keep[15:8] + prod_tgt[15:8];
		end
	end

	always_comb begin
		wk_d = mix_src;
		case (cmd.mix_ch)
			rlfe_pkg::CH_R: wk_d.cur.r = ch_new;
			rlfe_pkg::CH_G: wk_d.cur.g = ch_new;
			rlfe_pkg::CH_B: wk_d.cur.b = ch_new;
			default:        wk_d.cur.r = ch_new;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mix_en) begin
			wk_q <= wk_d;
		end
	end

	// write-back record
	always_comb begin
		if (cmd.wr_set) begin
			wr_rec.cur   = rec_rd.cur;
			wr_rec.start = rec_rd.cur;
			wr_rec.tgt   = color_q;
			wr_rec.pos   = '0;
			wr_rec.inc   = step;
		end else begin
			wr_rec = wk_q;
			// position stops once the fade reaches the target
			if (wk_q.pos[15:8] != rlfe_pkg::BLEND_FULL) begin
				wr_rec.pos = wk_q.pos + wk_q.inc;
			end
		end
	end

	// output register
	logic             out_valid_q;
	logic [5:0]       out_num_q;
	rlfe_pkg::color_t out_color_q;
	logic             out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_num_q   <= 6'(led_q);
			out_color_q <= wk_q.cur;
			out_last_q  <= (led_q == LED_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {2'b00, out_color_q.b, out_color_q.g, out_color_q.r, out_num_q};
	assign out_last  = out_last_q;

	// status back to the controller
	assign sts.in_mode      = in_mode;
	assign sts.in_target_ok = (in_idx == 8'd0) || (32'(in_idx) < LED_COUNT);
	assign sts.in_all       = (in_idx == 8'd0);
	assign sts.div_last     = (div_cnt_q == DIV_LAST);
	assign sts.led_last     = (led_q == LED_LAST);
	assign sts.set_single   = !all_q;
	assign sts.out_free     = !out_valid_q || out_ready;

endmodule

### rtl/rlfe_checker.sv
// port-level checks for the rgb led fade engine, bound to the top level
// depends on rgb_led_fade_engine_unit port names
module rlfe_checker #(
	parameter int LED_COUNT = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// the flagged result belongs to the highest led
	a_last_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] == 6'(LED_COUNT - 1))
		else $error("last flag on wrong led");

	// no new transaction while a tick is still walking the leds
	a_busy_walk: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready during tick walk");

	// a tick transaction makes the block busy at once
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
		else $error("input ready right after tick");

endmodule

bind rgb_led_fade_engine_unit rlfe_checker #(.LED_COUNT(LED_COUNT)) u_rlfe_checker (.*);

### tb/sv/testbench.sv
// self-checking testbench for rgb_led_fade_engine_unit: set and tick commands streamed in,
// per-led color reports checked against a fader model kept in a small scoreboard class
// depends on rlfe_pkg and the rtl of rgb_led_fade_engine_unit
`timescale 1ns / 1ps

module testbench;

	localparam int LEDS = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 80;
	localparam bit MODE_SET = 1'b0;
	localparam bit MODE_TICK = 1'b1;

	class fader_scoreboard;
		typedef struct {
			bit [5:0] num;
			bit [7:0] r;
			bit [7:0] g;
			bit [7:0] b;
			bit       last;
		} led_report_t;

		rlfe_pkg::color_t cur_c[LEDS];
		rlfe_pkg::color_t start_c[LEDS];
		rlfe_pkg::color_t tgt_c[LEDS];
		bit [15:0]   pos[LEDS];
		bit [15:0]   inc[LEDS];
		bit [7:0]    update_step;
		led_report_t reports[$];
		int          mismatches;
		int          checked;
		int          ticks;
		int          sets;

		function new();
			for (int i = 0; i < LEDS; i++) begin
				cur_c[i] = '0;
				start_c[i] = '0;
				tgt_c[i] = '0;
				pos[i] = '0;
				inc[i] = '0;
			end
			update_step = rlfe_pkg::UPDATE_STEP_RESET;
			mismatches = 0;
			checked = 0;
			ticks = 0;
			sets = 0;
		endfunction

		function bit [15:0] fade_step(bit [15:0] fade_time);
			int unsigned q;
			if (fade_time == 0)
				return 16'hFFFF;
			q = (32'd65535 * update_step) / fade_time;
			if (q > 32'd65535)
				q = 32'd65535;
			return q[15:0];
		endfunction

		function bit [7:0] blend_chan(bit [7:0] c, bit [7:0] t, int unsigned amt);
			int unsigned sum;
			sum = ((c * (256 - amt)) >> 8) + ((t * amt) >> 8);
			return sum[7:0];
		endfunction

		function void note_item(bit mode, bit [47:0] d);
			bit [7:0]    idx;
			bit [15:0]   step;
			int unsigned amt;
			led_report_t rep;
			idx = d[7:0];
			if (mode == MODE_SET) begin
				sets++;
				step = fade_step(d[47:32]);
				for (int i = 0; i < LEDS; i++) begin
					if (idx == 0 || idx == i) begin
						pos[i] = '0;
						inc[i] = step;
						start_c[i] = cur_c[i];
						tgt_c[i] = '{r: d[15:8], g: d[23:16], b: d[31:24]};
					end
				end
			end else begin
				ticks++;
				for (int i = 0; i < LEDS; i++) begin
					amt = 32'(pos[i][15:8]);
					if (amt == rlfe_pkg::BLEND_FULL) begin
						cur_c[i] = tgt_c[i];
					end else begin
						if (amt == rlfe_pkg::BLEND_NONE) begin
							cur_c[i] = start_c[i];
						end else begin
							cur_c[i].r = blend_chan(cur_c[i].r, tgt_c[i].r, amt);
							cur_c[i].g = blend_chan(cur_c[i].g, tgt_c[i].g, amt);
							cur_c[i].b = blend_chan(cur_c[i].b, tgt_c[i].b, amt);
						end
						pos[i] = pos[i] + inc[i];
					end
					rep.num = 6'(i);
					rep.r = cur_c[i].r;
					rep.g = cur_c[i].g;
					rep.b = cur_c[i].b;
					rep.last = (i == LEDS - 1);
					reports.push_back(rep);
				end
			end
		endfunction

		function void check_result(bit [31:0] d, bit last);
			led_report_t want;
			if (reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected led report: tdata=%08h tlast=%0b", d, last);
				return;
			end
			want = reports.pop_front();
			checked++;
			if (d[5:0] != want.num || d[13:6] != want.r || d[21:14] != want.g
					|| d[29:22] != want.b || d[31:30] != 2'b00 || last != want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("led report mismatch: expected led=%0d rgb=%02h_%02h_%02h last=%0b,",
						want.num, want.r, want.g, want.b, want.last);
					$display("  got led=%0d rgb=%02h_%02h_%02h pad=%0d last=%0b",
						d[5:0], d[13:6], d[21:14], d[29:22], d[31:30], last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	fader_scoreboard sb;
	bit          no_idle;
	bit          hold_req;
	int          hold_count;
	int unsigned cycle_count;
	int          step_settings;

	rgb_led_fade_engine_unit #(
		.LED_COUNT(LEDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic bit [47:0] set_word(bit [7:0] idx, bit [7:0] r, bit [7:0] g, bit [7:0] b,
			bit [15:0] ft);
		return {ft, b, g, r, idx};
	endfunction

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_item(bit mode, bit [47:0] d);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 13));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= mode;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(mode, d);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (sb.reports.size() > 0);
	endtask

	task automatic write_update_step(bit [7:0] v);
		wait_drained();
		// a set command leaves no report behind, so give the divider time to finish
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.update_step = v;
		step_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		int        sel;
		bit [7:0]  idx;
		bit [7:0]  r, g, b;
		bit [15:0] ft;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			send_item(MODE_TICK, 48'({$urandom, $urandom}));
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 15)
				idx = 8'd0;
			else if (sel < 88)
				idx = 8'($urandom_range(1, LEDS - 1));
			else
				idx = 8'($urandom_range(0, 255));
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			if ($urandom_range(0, 5) == 0) begin
				r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			sel = $urandom_range(0, 99);
			if (sel < 20)
				ft = 16'd0;
			else if (sel < 70)
				ft = 16'($urandom_range(1, 3000));
			else
				ft = 16'($urandom);
			send_item(MODE_SET, set_word(idx, r, g, b, ft));
		end
	endtask

	task automatic directed_items();
		send_item(MODE_TICK, 48'h0);
		// immediate fade to white on every led
		send_item(MODE_SET, set_word(8'd0, 8'hFF, 8'hFF, 8'hFF, 16'd0));
		send_item(MODE_TICK, 48'h0);
		send_item(MODE_TICK, 48'hFFFF_FFFF_FFFF);
		send_item(MODE_TICK, 48'h0);
		// slowest fade on the highest led
		send_item(MODE_SET, set_word(8'(LEDS - 1), 8'h00, 8'h00, 8'h00, 16'hFFFF));
		// out of range indexes are dropped
		send_item(MODE_SET, set_word(8'(LEDS), 8'h12, 8'h34, 8'h56, 16'd0));
		send_item(MODE_SET, set_word(8'hFF, 8'h00, 8'h00, 8'h00, 16'd0));
		// step saturates on the first, stays in range on the other two
		send_item(MODE_SET, set_word(8'd1, 8'hA5, 8'h5A, 8'h3C, 16'd1));
		send_item(MODE_SET, set_word(8'd3, 8'h00, 8'h80, 8'hFF, 16'd100));
		send_item(MODE_SET, set_word(8'd2, 8'h01, 8'hFE, 8'h7F, 16'd25));
		repeat (6) send_item(MODE_TICK, 48'h0);
		// retarget mid fade, start color comes from the current color
		send_item(MODE_SET, set_word(8'd3, 8'hFF, 8'h00, 8'h00, 16'd40));
		send_item(MODE_SET, set_word(8'd0, 8'h00, 8'h00, 8'h00, 16'hFFFF));
		repeat (3) send_item(MODE_TICK, 48'hFFFF_FFFF_FFFF);
	endtask

	// receiver: random stall per report, one long hold-off on request
	initial begin
		int stall;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(negedge clk);
					hold_count++;
				end
				hold_req = 1'b0;
			end
			stall = no_idle ? 0 : int'($urandom_range(0, 13));
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			sb.check_result(m_axis_tdata, m_axis_tlast);
			@(negedge clk);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		bit [7:0] step_list[4];
		sb = new();
		no_idle = 1'b0;
		hold_req = 1'b0;
		step_settings = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		step_list[0] = rlfe_pkg::UPDATE_STEP_RESET;
		step_list[1] = 8'd1;
		step_list[2] = 8'd255;
		step_list[3] = 8'($urandom_range(2, 254));
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0)
				write_update_step(step_list[ph]);
			else
				directed_items();
			for (int k = 0; k < 90; k++) begin
				no_idle = (k >= 30 && k < 45);
				if (ph == 2 && k == 50)
					hold_req = 1'b1;
				if (ph == 1 && k == 60)
					wait_drained();
				// keep offering ticks while the receiver holds off
				if (ph == 2 && k >= 50 && k < 60)
					send_item(MODE_TICK, 48'({$urandom, $urandom}));
				else
					random_item();
			end
		end
		no_idle = 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d set and %0d tick transactions, %0d led reports checked",
			sb.sets, sb.ticks, sb.checked);
		$display("update_step written %0d times (1, 255 and a random value), %0d mismatches",
			step_settings, sb.mismatches);
		if (sb.mismatches == 0 && sb.reports.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d led reports never arrived", sb.reports.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
